// ----- src/s2h_pkg.sv -----
// Package with constants and types for the single to half converter.
`default_nettype none
package s2h_pkg;
    localparam int unsigned SingleW = 32;
    localparam int unsigned HalfW = 16;
    localparam int unsigned ModeW = 2;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 2;

    localparam logic [CfgIdxW-1:0] CfgRoundingMode = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgTininess = 1'b1;

    localparam logic [ModeW-1:0] RmNearestEven = 2'd0;
    localparam logic [ModeW-1:0] RmTowardZero = 2'd1;
    localparam logic [ModeW-1:0] RmUp = 2'd2;
    localparam logic [ModeW-1:0] RmDown = 2'd3;

    localparam logic [8:0] ExpRebias = 9'h071;
    localparam logic [15:0] ImplicitOne = 16'h4000;
    localparam logic [8:0] MaxNormalExp = 9'h01D;
    localparam logic [4:0] HalfExpOnes = 5'h1F;
    localparam logic [3:0] GuardMask = 4'hF;
    localparam logic [3:0] GuardHalf = 4'h8;

    typedef struct packed {
        logic [HalfW-1:0] half_value;
        logic invalid;
        logic overflow;
        logic underflow;
        logic inexact;
    } t_result;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic tiny_before;
    } t_cfg;
endpackage
`default_nettype wire

// ----- src/s2h_core.sv -----
// Combinational conversion of one binary32 word to binary16 with exception flags.
`default_nettype none
module s2h_core (
    input  wire logic [31:0]          i_single,
    input  wire s2h_pkg::t_cfg        i_cfg,
    output s2h_pkg::t_result          o_result
);
    logic        sign;
    logic [7:0]  e;
    logic [22:0] f;
    logic [15:0] sig0;
    logic [15:0] sig;
    logic [15:0] incr;
    logic [8:0]  ex;
    logic        nonzero;
    logic [16:0] sum0;
    logic [16:0] sum1;
    logic [8:0]  nshift;
    logic [15:0] shifted;
    logic [15:0] lost_mask;
    logic        tiny;
    logic [3:0]  guard;
    logic [11:0] frac;
    logic        big;
    logic        subn;

    always_comb begin
        sign = i_single[31];
        e = i_single[30:23];
        f = i_single[22:0];
        sig0 = {2'b00, f[22:9]} | {15'd0, |f[8:0]};
        nonzero = (e != 8'd0) || (sig0 != 16'd0);
        sig = nonzero ? (sig0 | s2h_pkg::ImplicitOne) : sig0;
        ex = nonzero ? ({1'b0, e} - s2h_pkg::ExpRebias) : 9'd0;
        case (i_cfg.mode)
            s2h_pkg::RmNearestEven: incr = {12'd0, s2h_pkg::GuardHalf};
            s2h_pkg::RmTowardZero:  incr = 16'd0;
            s2h_pkg::RmUp:          incr = sign ? 16'd0 : {12'd0, s2h_pkg::GuardMask};
            s2h_pkg::RmDown:        incr = sign ? {12'd0, s2h_pkg::GuardMask} : 16'd0;
            default:                incr = 16'd0;
        endcase
        sum0 = {1'b0, sig} + {1'b0, incr};
        big = !ex[8] && ((ex > s2h_pkg::MaxNormalExp) ||
              ((ex == s2h_pkg::MaxNormalExp) && sum0[15]));
        subn = ex[8];
        nshift = -ex;
        tiny = i_cfg.tiny_before || (subn && (nshift > 9'd1)) || !sum0[15];
        lost_mask = 16'd0;
        if (nshift >= 9'd16) begin
            shifted = {15'd0, sig != 16'd0};
        end else begin
            lost_mask = ~(16'hFFFF << nshift[3:0]);
            shifted = (sig >> nshift[3:0]) | {15'd0, (sig & lost_mask) != 16'd0};
        end
        if (!subn) begin
            shifted = sig;
        end
        guard = shifted[3:0];
        sum1 = {1'b0, shifted} + {1'b0, incr};
        frac = sum1[15:4];
        if ((i_cfg.mode == s2h_pkg::RmNearestEven) && (guard == s2h_pkg::GuardHalf)) begin
            frac[0] = 1'b0;
        end
        o_result = '0;
        if (e == 8'hFF) begin
            if (f != 23'd0) begin
                o_result.invalid = !f[22];
                o_result.half_value = {sign, s2h_pkg::HalfExpOnes, 1'b1, f[21:13]};
            end else begin
                o_result.half_value = {sign, s2h_pkg::HalfExpOnes, 10'd0};
            end
        end else if (big) begin
            o_result.overflow = 1'b1;
            o_result.inexact = 1'b1;
            o_result.half_value = {sign, 15'd0} | ((incr == 16'd0) ? 16'h7BFF : 16'h7C00);
        end else begin
            o_result.inexact = guard != 4'd0;
            o_result.underflow = subn && tiny && (guard != 4'd0);
            o_result.half_value = {sign, 15'd0} + {1'b0, (subn ? 5'd0 : ex[4:0]), 10'd0}
                                  + {4'd0, frac};
        end
    end
endmodule
`default_nettype wire

// ----- src/single_to_half_float_convert.sv -----
// Top level of the single to half precision converter with registered input and output.
// Usage: a binary32 request on i_single_value is taken when i_valid and o_ready are high.
// The word is first held in an input register, converted by one short combinational
// stage, and the result lands in the output register with its four flags.
// o_valid rises once an accepted request has moved from the input register into the
// output register. Throughput is one request per cycle while i_ready is high: the
// input register refills whenever the output register is free or is being read in
// the same cycle, so a new request can be taken every cycle.
// When the receiver holds i_ready low, the output keeps its result and the input
// register holds one more request; o_ready falls only while both are full.
// The configuration channel writes the rounding mode (index 0) and the tininess
// rule (index 1); it is always ready and must only be used while the block is idle.
// Reset clears both valid bits, the rounding mode to nearest even and the tininess
// rule to after rounding.
`default_nettype none
module single_to_half_float_convert (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [s2h_pkg::SingleW-1:0]   i_single_value,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [s2h_pkg::HalfW-1:0]          o_half_value,
    output logic                               o_flag_invalid,
    output logic                               o_flag_overflow,
    output logic                               o_flag_underflow,
    output logic                               o_flag_inexact,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [s2h_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [s2h_pkg::CfgDataW-1:0]  i_cfg_data
);
    logic              r_in_valid;
    logic [31:0]       r_in_data;
    logic              r_out_valid;
    s2h_pkg::t_result  r_out;
    s2h_pkg::t_cfg     r_cfg;
    s2h_pkg::t_result  w_res;
    logic              w_move;

    assign w_move = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_move;
    assign o_cfg_ready = 1'b1;

    s2h_core u_core (
        .i_single(r_in_data),
        .i_cfg(r_cfg),
        .o_result(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    s2h_pkg::CfgRoundingMode: r_cfg.mode <= i_cfg_data;
                    s2h_pkg::CfgTininess:     r_cfg.tiny_before <= i_cfg_data[0];
                    default:                  r_cfg <= r_cfg;
                endcase
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_data <= i_single_value;
        end
        if (w_move) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_half_value = r_out.half_value;
    assign o_flag_invalid = r_out.invalid;
    assign o_flag_overflow = r_out.overflow;
    assign o_flag_underflow = r_out.underflow;
    assign o_flag_inexact = r_out.inexact;
endmodule
`default_nettype wire

// ----- src/s2h_checker.sv -----
// Port-level checker for the single to half converter, bound to the top level.
`default_nettype none
module s2h_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_ready,
    input wire logic [15:0] o_half_value,
    input wire logic        o_flag_invalid,
    input wire logic        o_flag_overflow,
    input wire logic        o_flag_underflow,
    input wire logic        o_flag_inexact
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_half_value))
        else $error("result changed under stall");
    a_ovf_inx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flag_overflow |-> o_flag_inexact)
        else $error("overflow without inexact");
    a_unf_inx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flag_underflow |-> o_flag_inexact)
        else $error("underflow without inexact");
    a_inv_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flag_invalid |-> (o_half_value[14:9] == 6'h3F) && !o_flag_inexact)
        else $error("invalid without quiet NaN");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready while output empty");
endmodule

bind single_to_half_float_convert s2h_checker u_s2h_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_ready(o_ready),
    .o_half_value(o_half_value),
    .o_flag_invalid(o_flag_invalid),
    .o_flag_overflow(o_flag_overflow),
    .o_flag_underflow(o_flag_underflow),
    .o_flag_inexact(o_flag_inexact)
);
`default_nettype wire

// ----- tb/single_to_half_float_convert_test.sv -----
// Testbench for the single to half converter: queued requests, a scoreboard of predicted results.
`timescale 1ns / 100ps
`default_nettype none
module single_to_half_float_convert_test;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_single_value;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_half_value;
    logic        o_flag_invalid;
    logic        o_flag_overflow;
    logic        o_flag_underflow;
    logic        o_flag_inexact;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [1:0]  i_cfg_data;

    single_to_half_float_convert dut (.*);

    logic [31:0]               pending_words[$];
    s2h_pkg::t_result          expected_halves[$];
    logic [s2h_pkg::ModeW-1:0] cur_mode;
    logic        cur_tiny_before;
    int          fail_count;
    int          converted_count;
    int          hold_off_cycles;
    bit          stall_request;
    bit          stall_taken;
    bit          last_accepted;
    bit          idle_enable;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [31:0] jam_shift(logic [31:0] v, int unsigned n);
        logic [63:0] wide;
        if (n == 0) begin
            return v;
        end
        if (n >= 32) begin
            return {31'b0, v != 0};
        end
        wide = {v, 32'b0} >> n;
        return wide[63:32] | {31'b0, wide[31:0] != 0};
    endfunction

    function automatic s2h_pkg::t_result convert_to_half(logic [31:0] x);
        s2h_pkg::t_result r;
        logic        sgn;
        logic [7:0]  ex8;
        logic [22:0] fr;
        logic [31:0] sig;
        logic [31:0] incr;
        logic [31:0] frac;
        logic [3:0]  guard;
        int          ex;
        bit          tiny;
        sgn = x[31];
        ex8 = x[30:23];
        fr = x[22:0];
        r = '0;
        if (ex8 == 8'hFF) begin
            if (fr != 0) begin
                r.invalid = !fr[22];
                r.half_value = {sgn, s2h_pkg::HalfExpOnes, 1'b1, fr[21:13]};
            end else begin
                r.half_value = {sgn, s2h_pkg::HalfExpOnes, 10'b0};
            end
            return r;
        end
        sig = jam_shift({9'b0, fr}, 9);
        ex = 0;
        if (ex8 != 0 || sig != 0) begin
            sig |= 32'(s2h_pkg::ImplicitOne);
            ex = int'(ex8) - int'(s2h_pkg::ExpRebias);
        end
        case (cur_mode)
            s2h_pkg::RmNearestEven: incr = 32'(s2h_pkg::GuardHalf);
            s2h_pkg::RmTowardZero:  incr = 0;
            s2h_pkg::RmUp:          incr = sgn ? 0 : 32'(s2h_pkg::GuardMask);
            default:                incr = sgn ? 32'(s2h_pkg::GuardMask) : 0;
        endcase
        if (ex > int'(s2h_pkg::MaxNormalExp) ||
            (ex == int'(s2h_pkg::MaxNormalExp) && sig + incr >= 32'h8000)) begin
            r.overflow = 1'b1;
            r.inexact = 1'b1;
            r.half_value = {sgn, (incr == 0) ? 15'h7BFF : 15'h7C00};
            return r;
        end
        if (ex < 0) begin
            tiny = cur_tiny_before || ex < -1 || sig + incr < 32'h8000;
            sig = jam_shift(sig, -ex);
            ex = 0;
            r.underflow = tiny && sig[3:0] != 0;
        end
        guard = sig[3:0];
        r.inexact = guard != 0;
        frac = (sig + incr) >> 4;
        if (cur_mode == s2h_pkg::RmNearestEven && guard == s2h_pkg::GuardHalf) begin
            frac[0] = 1'b0;
        end
        r.half_value = 16'(({sgn, 15'b0}) + (ex << 10) + frac);
        return r;
    endfunction

    // Prediction happens when a request is accepted.
    always @(posedge i_clk) begin
        last_accepted <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            expected_halves.push_back(convert_to_half(i_single_value));
            void'(pending_words.pop_front());
        end
    end

    // A request that was not taken stays offered with the same word.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_single_value <= '0;
        end else if (i_valid && !last_accepted) begin
            i_valid <= 1'b1;
        end else if (pending_words.size() != 0 &&
                     !(idle_enable && $urandom_range(99) < 26)) begin
            i_valid <= 1'b1;
            i_single_value <= pending_words[0];
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Monitor and receiver.
    always @(posedge i_clk) begin
        s2h_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_halves.size() == 0) begin
                $error("result 0x%04h arrived with no request outstanding", o_half_value);
                fail_count++;
            end else begin
                want = expected_halves.pop_front();
                converted_count++;
                if (o_half_value !== want.half_value) begin
                    $error("half_value expected 0x%04h actual 0x%04h", want.half_value,
                           o_half_value);
                    fail_count++;
                end
                if (o_flag_invalid !== want.invalid) begin
                    $error("flag_invalid expected %0b actual %0b", want.invalid, o_flag_invalid);
                    fail_count++;
                end
                if (o_flag_overflow !== want.overflow) begin
                    $error("flag_overflow expected %0b actual %0b", want.overflow,
                           o_flag_overflow);
                    fail_count++;
                end
                if (o_flag_underflow !== want.underflow) begin
                    $error("flag_underflow expected %0b actual %0b", want.underflow,
                           o_flag_underflow);
                    fail_count++;
                end
                if (o_flag_inexact !== want.inexact) begin
                    $error("flag_inexact expected %0b actual %0b", want.inexact, o_flag_inexact);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_request && !stall_taken) begin
            stall_taken <= 1'b1;
            hold_off_cycles <= 59;
            i_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(idle_enable && $urandom_range(99) < 26);
        end
    end

    task automatic write_register(logic [0:0] idx, logic [1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        #0;
        while (!o_cfg_ready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        if (idx == s2h_pkg::CfgRoundingMode) begin
            cur_mode = val;
        end else begin
            cur_tiny_before = val[0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || i_valid || expected_halves.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_word();
        logic [7:0] ex8;
        case ($urandom_range(9))
            0: return $urandom();
            1: ex8 = 8'hFF;
            2: ex8 = 8'h00;
            3: ex8 = 8'(8'd142 + $urandom_range(2));
            default: ex8 = 8'(8'd98 + $urandom_range(46));
        endcase
        return {1'($urandom()), ex8, 23'($urandom())};
    endfunction

    task automatic random_batch(int count);
        repeat (count) pending_words.push_back(random_word());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cur_mode = s2h_pkg::RmNearestEven;
        cur_tiny_before = 1'b0;
        fail_count = 0;
        converted_count = 0;
        stall_request = 1'b0;
        idle_enable = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int m = 0; m < 4; m++) begin
            write_register(s2h_pkg::CfgRoundingMode, 2'(m));
            write_register(s2h_pkg::CfgTininess, 2'(m & 1));
            pending_words.push_back(32'h00000000); pending_words.push_back(32'h80000000);
            pending_words.push_back(32'h7F800000); pending_words.push_back(32'hFF800000);
            pending_words.push_back(32'h7FC00000); pending_words.push_back(32'hFFA00001);
            pending_words.push_back(32'h7F80FFFF); pending_words.push_back(32'h00000001);
            pending_words.push_back(32'h807FFFFF); pending_words.push_back(32'h477FE000);
            pending_words.push_back(32'h477FF000); pending_words.push_back(32'hC77FF000);
            pending_words.push_back(32'h7F7FFFFF); pending_words.push_back(32'h387FC000);
            pending_words.push_back(32'h387FF000); pending_words.push_back(32'hB87FE001);
            pending_words.push_back(32'h33800000); pending_words.push_back(32'h33000001);
            pending_words.push_back(32'h3F801000); pending_words.push_back(32'h3F803000);
            pending_words.push_back(32'h3F800FFF); pending_words.push_back(32'hFFFFFFFF);
            wait_drained();
        end

        for (int phase = 0; phase < 8; phase++) begin
            write_register(s2h_pkg::CfgRoundingMode, 2'($urandom_range(3)));
            write_register(s2h_pkg::CfgTininess, 2'($urandom_range(1)));
            if (phase == 2) begin
                idle_enable = 1'b0;
            end else begin
                idle_enable = 1'b1;
            end
            if (phase == 4) begin
                stall_request = 1'b1;
            end
            random_batch(133);
            wait_drained();
        end

        $display("Converted %0d words across all rounding modes and both tininess rules,",
                 converted_count);
        $display("covering NaNs, infinities, zeros, subnormals, overflow and rounding ties.");
        if (fail_count == 0) begin
            $display("PASS single_to_half_float_convert");
        end else begin
            $display("FAIL single_to_half_float_convert");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL single_to_half_float_convert");
        $finish;
    end
endmodule
`default_nettype wire
